>>> rtl/core/best_fit_heap_allocator_defines.svh
// Assertion macros for the best-fit heap allocator.
// In synthesis builds the macros expand to nothing.
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define BFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define BFA_ASSERT(lbl, clk, rst_n, prop)
`define BFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/bfa_pkg.sv
package bfa_pkg;

  localparam int POOL_BYTES   = 4096;
  localparam int ALIGN_BYTES  = 8;
  localparam int ALIGN_SH     = 3;
  localparam int HEADER_BYTES = 8;
  localparam int SPLIT_MIN    = HEADER_BYTES * 2;
  localparam int MAX_FREE     = 256;
  localparam int SUM_MAX      = 8191;

  localparam int OFF_W   = 12;
  localparam int SIZE_W  = 13;
  localparam int LIST_AW = 8;
  localparam int CNT_W   = 9;
  localparam int SLOT_AW = 9;
  localparam int FAIL_W  = 16;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_STATUS  = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_A_RD, ST_A_CHK, ST_RM_RD, ST_RM_WR, ST_A_SPLIT, ST_A_SLOT,
    ST_R_SLOT,
    ST_INS_START, ST_INS_RD, ST_INS_CHK, ST_SH_RD, ST_SH_WR, ST_INS_PUT,
    ST_T_RD, ST_T_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } fl_entry_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [LIST_AW-1:0] addr;
    fl_entry_t          wdata;
  } list_req_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [SLOT_AW-1:0] addr;
    logic [SIZE_W-1:0]  wdata;
  } slot_req_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } ctrl_stat_t;

endpackage

>>> rtl/core/bfa_list_mem.sv
// Free list storage: one entry per free block, sorted by size.
module bfa_list_mem import bfa_pkg::*; (
  input  logic      clk_i,
  input  list_req_t req_i,
  output fl_entry_t rdata_o
);

  fl_entry_t mem [MAX_FREE];
  fl_entry_t rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bfa_slot_mem.sv
// Block size recorded per payload slot.
module bfa_slot_mem import bfa_pkg::*; (
  input  logic              clk_i,
  input  slot_req_t         req_i,
  output logic [SIZE_W-1:0] rdata_o
);

  logic [SIZE_W-1:0] mem [2**SLOT_AW];
  logic [SIZE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bfa_ctrl.sv
// Sequencer: walks, shifts and sums the free list, records block sizes.
module bfa_ctrl import bfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [12:0]       request_bytes_i,
  input  logic [11:0]       release_offset_i,
  output list_req_t         list_req_o,
  input  fl_entry_t         list_rdata_i,
  output slot_req_t         slot_req_o,
  input  logic [SIZE_W-1:0] slot_rdata_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              granted_o,
  output logic [11:0]       payload_offset_o,
  output logic [12:0]       free_bytes_o,
  output logic [12:0]       low_water_bytes_o,
  output logic [15:0]       fail_count_o,
  output ctrl_stat_t        stat_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [CNT_W-1:0]  count_q, count_d, idx_q, idx_d, pos_q, pos_d;
  logic [SIZE_W-1:0] want_q, want_d, hit_size_q, hit_size_d;
  logic [OFF_W-1:0]  hit_off_q, hit_off_d, rel_q, rel_d;
  logic [OFF_W-1:0]  ins_off_q, ins_off_d;
  logic [SIZE_W-1:0] ins_size_q, ins_size_d, slot_size_q, slot_size_d;
  logic [SIZE_W-1:0] sum_q, sum_d, low_q, low_d;
  logic [FAIL_W-1:0] fail_q, fail_d;
  logic              res_grant_q, res_grant_d;
  logic [OFF_W-1:0]  res_pay_q, res_pay_d;
  logic [SIZE_W-1:0] res_sum_q, res_sum_d;
  logic              out_valid_q, out_valid_d, out_grant_q, out_grant_d;
  logic [OFF_W-1:0]  out_pay_q, out_pay_d;
  logic [SIZE_W-1:0] out_sum_q, out_sum_d, out_low_q, out_low_d;
  logic [FAIL_W-1:0] out_fail_q, out_fail_d;

  logic [13:0]       want_full, sum_add;
  logic [SIZE_W-1:0] sum_sat, rem;
  logic [CNT_W-1:0]  idx_inc;
  logic [FAIL_W-1:0] fail_inc;
  logic [OFF_W-1:0]  hit_pay;

  // request arithmetic
  assign want_full = ({1'b0, request_bytes_i} + 14'(HEADER_BYTES + ALIGN_BYTES - 1))
                     & ~14'(ALIGN_BYTES - 1);
  assign sum_add   = {1'b0, sum_q} + {1'b0, list_rdata_i.size};
  assign sum_sat   = (sum_add > 14'(SUM_MAX)) ? SIZE_W'(SUM_MAX) : sum_add[SIZE_W-1:0];
  assign rem       = hit_size_q - want_q;
  assign idx_inc   = idx_q + 1'b1;
  assign fail_inc  = (fail_q != {FAIL_W{1'b1}}) ? fail_q + 1'b1 : fail_q;
  assign hit_pay   = hit_off_q + OFF_W'(HEADER_BYTES);

  always_comb begin
    state_d = state_q;  op_d = op_q;  count_d = count_q;
    idx_d = idx_q;  pos_d = pos_q;  want_d = want_q;
    hit_size_d = hit_size_q;  hit_off_d = hit_off_q;  rel_d = rel_q;
    ins_off_d = ins_off_q;  ins_size_d = ins_size_q;  slot_size_d = slot_size_q;
    sum_d = sum_q;  low_d = low_q;  fail_d = fail_q;
    res_grant_d = res_grant_q;  res_pay_d = res_pay_q;  res_sum_d = res_sum_q;
    out_valid_d = out_valid_q;  out_grant_d = out_grant_q;  out_pay_d = out_pay_q;
    out_sum_d = out_sum_q;  out_low_d = out_low_q;  out_fail_d = out_fail_q;
    list_req_o = '0;
    slot_req_o = '0;
    in_stall_o = 1'b1;

    // output register drains independently
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      // write the whole pool as the single free block
      ST_INIT: begin
        list_req_o.en = 1'b1;
        list_req_o.we = 1'b1;
        list_req_o.addr = '0;
        list_req_o.wdata.off = '0;
        list_req_o.wdata.size = SIZE_W'(POOL_BYTES);
        state_d = ST_IDLE;
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        slot_req_o.en = in_valid_i;
        slot_req_o.addr = release_offset_i[OFF_W-1:ALIGN_SH];
        if (in_valid_i) begin
          op_d = op_e'(op_i);
          rel_d = release_offset_i;
          want_d = want_full[SIZE_W-1:0];
          res_grant_d = 1'b0;
          res_pay_d = '0;
          res_sum_d = '0;
          idx_d = '0;
          sum_d = '0;
          state_d = ST_DONE;
          case (op_e'(op_i))
            OP_ALLOC: begin
              if (request_bytes_i == '0 || want_full >= 14'(POOL_BYTES) || count_q == '0) begin
                fail_d = fail_inc;
              end else begin
                state_d = ST_A_RD;
              end
            end
            OP_RELEASE: begin
              if (release_offset_i >= OFF_W'(HEADER_BYTES) && count_q != CNT_W'(MAX_FREE)) begin
                state_d = ST_R_SLOT;
              end
            end
            OP_STATUS: begin
              if (count_q == '0) begin
                if (low_q != '0) low_d = '0;
              end else begin
                state_d = ST_T_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // best-fit scan: first entry large enough
      ST_A_RD: begin
        list_req_o.en = 1'b1;
        list_req_o.addr = idx_q[LIST_AW-1:0];
        state_d = ST_A_CHK;
      end
      ST_A_CHK: begin
        if (list_rdata_i.size >= want_q) begin
          hit_off_d = list_rdata_i.off;
          hit_size_d = list_rdata_i.size;
          idx_d = idx_inc;
          if (idx_inc < count_q) begin
            state_d = ST_RM_RD;
          end else begin
            count_d = count_q - 1'b1;
            state_d = ST_A_SPLIT;
          end
        end else if (idx_inc >= count_q) begin
          fail_d = fail_inc;
          state_d = ST_DONE;
        end else begin
          idx_d = idx_inc;
          state_d = ST_A_RD;
        end
      end

      // close the gap: move entry idx down by one
      ST_RM_RD: begin
        list_req_o.en = 1'b1;
        list_req_o.addr = idx_q[LIST_AW-1:0];
        state_d = ST_RM_WR;
      end
      ST_RM_WR: begin
        list_req_o.en = 1'b1;
        list_req_o.we = 1'b1;
        list_req_o.addr = LIST_AW'(idx_q - 1'b1);
        list_req_o.wdata = list_rdata_i;
        idx_d = idx_inc;
        if (idx_inc < count_q) begin
          state_d = ST_RM_RD;
        end else begin
          count_d = count_q - 1'b1;
          state_d = ST_A_SPLIT;
        end
      end

      ST_A_SPLIT: begin
        if (rem > SIZE_W'(SPLIT_MIN)) begin
          ins_off_d = hit_off_q + want_q[OFF_W-1:0];
          ins_size_d = rem;
          slot_size_d = want_q;
          state_d = ST_INS_START;
        end else begin
          slot_size_d = hit_size_q;
          state_d = ST_A_SLOT;
        end
      end

      // record the granted size at its payload slot
      ST_A_SLOT: begin
        slot_req_o.en = 1'b1;
        slot_req_o.we = 1'b1;
        slot_req_o.addr = hit_pay[OFF_W-1:ALIGN_SH];
        slot_req_o.wdata = slot_size_q;
        res_grant_d = 1'b1;
        res_pay_d = hit_pay;
        state_d = ST_DONE;
      end

      ST_R_SLOT: begin
        ins_size_d = slot_rdata_i;
        ins_off_d = rel_q - OFF_W'(HEADER_BYTES);
        state_d = ST_INS_START;
      end

      // sorted insert: find position, shift tail up, write
      ST_INS_START: begin
        idx_d = '0;
        pos_d = '0;
        state_d = (count_q == '0) ? ST_INS_PUT : ST_INS_RD;
      end
      ST_INS_RD: begin
        list_req_o.en = 1'b1;
        list_req_o.addr = idx_q[LIST_AW-1:0];
        state_d = ST_INS_CHK;
      end
      ST_INS_CHK: begin
        if (list_rdata_i.size >= ins_size_q) begin
          pos_d = idx_q;
          idx_d = count_q - 1'b1;
          state_d = ST_SH_RD;
        end else if (idx_inc == count_q) begin
          pos_d = count_q;
          state_d = ST_INS_PUT;
        end else begin
          idx_d = idx_inc;
          state_d = ST_INS_RD;
        end
      end
      ST_SH_RD: begin
        list_req_o.en = 1'b1;
        list_req_o.addr = idx_q[LIST_AW-1:0];
        state_d = ST_SH_WR;
      end
      ST_SH_WR: begin
        list_req_o.en = 1'b1;
        list_req_o.we = 1'b1;
        list_req_o.addr = idx_inc[LIST_AW-1:0];
        list_req_o.wdata = list_rdata_i;
        if (idx_q == pos_q) begin
          state_d = ST_INS_PUT;
        end else begin
          idx_d = idx_q - 1'b1;
          state_d = ST_SH_RD;
        end
      end
      ST_INS_PUT: begin
        list_req_o.en = 1'b1;
        list_req_o.we = 1'b1;
        list_req_o.addr = pos_q[LIST_AW-1:0];
        list_req_o.wdata.off = ins_off_q;
        list_req_o.wdata.size = ins_size_q;
        count_d = count_q + 1'b1;
        state_d = (op_q == OP_ALLOC) ? ST_A_SLOT : ST_DONE;
      end

      // status: saturating sum of free sizes
      ST_T_RD: begin
        list_req_o.en = 1'b1;
        list_req_o.addr = idx_q[LIST_AW-1:0];
        state_d = ST_T_CHK;
      end
      ST_T_CHK: begin
        sum_d = sum_sat;
        idx_d = idx_inc;
        if (idx_inc == count_q) begin
          res_sum_d = sum_sat;
          if (low_q > sum_sat) low_d = sum_sat;
          state_d = ST_DONE;
        end else begin
          state_d = ST_T_RD;
        end
      end

      // hand the result to the output register
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_grant_d = res_grant_q;
          out_pay_d = res_pay_q;
          out_sum_d = res_sum_q;
          out_low_d = low_q;
          out_fail_d = fail_q;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      count_q <= CNT_W'(1);
      low_q <= SIZE_W'(POOL_BYTES);
      fail_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      low_q <= low_d;
      fail_q <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d;  idx_q <= idx_d;  pos_q <= pos_d;  want_q <= want_d;
    hit_size_q <= hit_size_d;  hit_off_q <= hit_off_d;  rel_q <= rel_d;
    ins_off_q <= ins_off_d;  ins_size_q <= ins_size_d;  slot_size_q <= slot_size_d;
    sum_q <= sum_d;
    res_grant_q <= res_grant_d;  res_pay_q <= res_pay_d;  res_sum_q <= res_sum_d;
    out_grant_q <= out_grant_d;  out_pay_q <= out_pay_d;  out_sum_q <= out_sum_d;
    out_low_q <= out_low_d;  out_fail_q <= out_fail_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_o         = out_grant_q;
  assign payload_offset_o  = out_pay_q;
  assign free_bytes_o      = out_sum_q;
  assign low_water_bytes_o = out_low_q;
  assign fail_count_o      = out_fail_q;
  assign stat_o.busy       = (state_q != ST_IDLE);
  assign stat_o.count      = count_q;

endmodule

>>> rtl/core/best_fit_heap_allocator.sv
// Best-fit heap allocator over a 4096-byte pool, free list sorted by size.
// Request channel: in_valid_i/in_stall_o with op_i (allocate, release,
// status), request_bytes_i and release_offset_i. Result channel:
// out_valid_o/out_stall_i with granted_o, payload_offset_o, free_bytes_o,
// low_water_bytes_o and fail_count_o; exactly one result per request.
// One request is worked at a time. The free blocks are held in the list
// memory (single port, registered read). A status request reads and sums
// every entry; a release compares entries until its position, moves the
// rest up and writes the block; an allocate scans entries, moves the tail
// down over the hit, then inserts any split remainder. Every list access
// is a read and then a compare or write on that one port.
// After reset ST_INIT writes the initial free block; in_stall_o is high
// until then. The result sits in an output register: a new request is taken
// while it waits, and the next result holds until out_stall_i drops.
`include "best_fit_heap_allocator_defines.svh"
module best_fit_heap_allocator import bfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [12:0] request_bytes_i,
  input  logic [11:0] release_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        granted_o,
  output logic [11:0] payload_offset_o,
  output logic [12:0] free_bytes_o,
  output logic [12:0] low_water_bytes_o,
  output logic [15:0] fail_count_o
);

  list_req_t         list_req;
  fl_entry_t         list_rdata;
  slot_req_t         slot_req;
  logic [SIZE_W-1:0] slot_rdata;
  ctrl_stat_t        stat;

  bfa_list_mem u_list (
    .clk_i   (clk_i),
    .req_i   (list_req),
    .rdata_o (list_rdata)
  );

  bfa_slot_mem u_slot (
    .clk_i   (clk_i),
    .req_i   (slot_req),
    .rdata_o (slot_rdata)
  );

  bfa_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .request_bytes_i   (request_bytes_i),
    .release_offset_i  (release_offset_i),
    .list_req_o        (list_req),
    .list_rdata_i      (list_rdata),
    .slot_req_o        (slot_req),
    .slot_rdata_i      (slot_rdata),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_o         (granted_o),
    .payload_offset_o  (payload_offset_o),
    .free_bytes_o      (free_bytes_o),
    .low_water_bytes_o (low_water_bytes_o),
    .fail_count_o      (fail_count_o),
    .stat_o            (stat)
  );

  // free list never overflows its memory
  `BFA_ASSERT(a_count_max, clk_i, rst_ni, stat.count <= CNT_W'(MAX_FREE))
  // a grant carries a real payload offset and no free sum
  `BFA_ASSERT_IMPL(a_grant_pay, clk_i, rst_ni, out_valid_o && granted_o,
    payload_offset_o >= 12'(HEADER_BYTES) && free_bytes_o == '0)
  // requests are only taken while the sequencer is idle
  `BFA_ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, stat.busy, in_stall_o)
  // a list write never lands past the fill count
  `BFA_ASSERT_IMPL(a_wr_range, clk_i, rst_ni, list_req.en && list_req.we,
    CNT_W'(list_req.addr) <= stat.count)

endmodule
